// ----- hw/rtl/psrs_pkg.sv -----
`timescale 1ns / 1ps

package psrs_pkg;

  // byte offset counter width within a section
  localparam int OFFSET_BITS = 32;
  localparam int UNIT_BITS = OFFSET_BITS - 1;
  localparam int COUNT_BITS = 16;
  localparam int LEN_BITS = 17;
  localparam int ADDR_BITS = 64;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 64;

  // printable character bounds and accepted control characters
  localparam logic [15:0] CHAR_LOW = 16'h0020;
  localparam logic [15:0] CHAR_HIGH = 16'h007E;
  localparam logic [15:0] CHAR_TAB = 16'h0009;
  localparam logic [15:0] CHAR_LF = 16'h000A;
  localparam logic [15:0] CHAR_CR = 16'h000D;

  // reset values of the configuration registers
  localparam logic [ADDR_BITS-1:0] RESET_SECTION_BASE = '0;
  localparam logic [COUNT_BITS-1:0] RESET_MIN_RUN = 16'd4;
  localparam logic [COUNT_BITS-1:0] RESET_MAX_RUN = 16'd1024;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SECTION_BASE = 8'd0,
    REG_MIN_RUN_LENGTH = 8'd1,
    REG_MAX_RUN_LENGTH = 8'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_section;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] string_address;
    logic [LEN_BITS-1:0]  byte_length;
    logic                 is_wide;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  section_base;
    logic [COUNT_BITS-1:0] min_run_length;
    logic [COUNT_BITS-1:0] max_run_length;
  } cfg_t;

  // what a scanner reports for the element it was just given
  typedef struct packed {
    logic                   hit;
    logic [OFFSET_BITS-1:0] start;
    logic [COUNT_BITS-1:0]  count;
  } scan_status_t;

  function automatic logic printable(input logic [15:0] v);
    return (v >= CHAR_LOW && v <= CHAR_HIGH) || v == CHAR_TAB || v == CHAR_LF ||
           v == CHAR_CR;
  endfunction

endpackage

// ----- hw/rtl/psrs_scan.sv -----
`timescale 1ns / 1ps

module psrs_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             clear,
  input  logic [15:0]                      elem,
  input  logic [psrs_pkg::OFFSET_BITS-1:0] where,
  input  psrs_pkg::cfg_t                   cfg,
  output psrs_pkg::scan_status_t           status
);

  logic                             in_run;
  logic                             in_run_next;
  logic [psrs_pkg::OFFSET_BITS-1:0] start;
  logic [psrs_pkg::OFFSET_BITS-1:0] start_next;
  logic [psrs_pkg::COUNT_BITS-1:0]  count;
  logic [psrs_pkg::COUNT_BITS-1:0]  count_next;
  logic                             hit;
  logic                             is_print;

  assign is_print = psrs_pkg::printable(elem);

  // run tracking for one element
  always_comb begin
    in_run_next = in_run;
    start_next = start;
    count_next = count;
    hit = 1'b0;
    if (step) begin
      if (in_run) begin
        if (count < cfg.max_run_length && is_print) begin
          count_next = count + 16'd1;
        end else begin
          hit = (elem == 16'h0000) && (count >= cfg.min_run_length);
          in_run_next = 1'b0;
        end
      end else if (is_print && cfg.max_run_length != '0) begin
        in_run_next = 1'b1;
        start_next = where;
        count_next = 16'd1;
      end
    end
    // section end drops whatever is open
    if (clear) begin
      in_run_next = 1'b0;
      start_next = '0;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      start <= '0;
      count <= '0;
    end else begin
      in_run <= in_run_next;
      start <= start_next;
      count <= count_next;
    end
  end

  // report the run as it stood before this element
  assign status.hit = hit;
  assign status.start = start;
  assign status.count = count;

  a_run_has_chars: assert property (@(posedge clk) disable iff (rst)
    in_run |-> count != '0)
    else $error("open run with zero characters");

  a_clear_closes: assert property (@(posedge clk) disable iff (rst)
    clear |=> !in_run)
    else $error("run still open after section end");

endmodule

// ----- hw/rtl/printable_string_run_scanner.sv -----
`timescale 1ns / 1ps

// Scans a section one byte per item for printable ASCII runs and UTF-16LE runs at once and
// reports each run that a zero terminator ends and that holds at least min_run_length
// characters, as section_base plus start offset, byte length and a wide flag. A new byte
// can be accepted each clock while the result side does not stall; each byte makes a
// single pass through the two run counters between the input register and the result
// register, which takes a run's result as its terminating byte leaves the input register.
// Offsets count modulo 2^32 within the section; the last byte of a section returns both
// scanners and the offset to zero, dropping open runs and a trailing odd byte. Write
// configuration only while idle.

module printable_string_run_scanner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psrs_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psrs_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [psrs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  psrs_pkg::cfg_t                   cfg;
  psrs_pkg::in_item_t               s1_item;
  logic                             s1_valid;
  logic                             advance;
  logic [psrs_pkg::OFFSET_BITS-1:0] pos;
  logic [7:0]                       held_low_byte;
  logic                             odd;
  logic                             last;
  logic [15:0]                      narrow_elem;
  logic [15:0]                      wide_elem;
  logic [psrs_pkg::OFFSET_BITS-1:0] wide_where;
  psrs_pkg::scan_status_t           narrow_status;
  psrs_pkg::scan_status_t           wide_status;
  psrs_pkg::out_item_t              result_next;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.section_base <= psrs_pkg::RESET_SECTION_BASE;
      cfg.min_run_length <= psrs_pkg::RESET_MIN_RUN;
      cfg.max_run_length <= psrs_pkg::RESET_MAX_RUN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psrs_pkg::REG_SECTION_BASE: cfg.section_base <= cfg_data;
        psrs_pkg::REG_MIN_RUN_LENGTH: cfg.min_run_length <= cfg_data[15:0];
        psrs_pkg::REG_MAX_RUN_LENGTH: cfg.max_run_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register, moves on whenever the result register is free
  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // byte offset and the low byte of the current UTF-16 unit
  assign odd = pos[0];
  assign last = s1_item.last_in_section;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      held_low_byte <= '0;
    end else if (advance) begin
      if (last) begin
        pos <= '0;
        held_low_byte <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (!odd) begin
          held_low_byte <= s1_item.data_byte;
        end
      end
    end
  end

  assign narrow_elem = {8'h00, s1_item.data_byte};
  assign wide_elem = {s1_item.data_byte, held_low_byte};
  assign wide_where = {1'b0, pos[psrs_pkg::OFFSET_BITS-1:1]};

  psrs_scan u_narrow (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .clear  (advance && last),
    .elem   (narrow_elem),
    .where  (pos),
    .cfg    (cfg),
    .status (narrow_status)
  );

  psrs_scan u_wide (
    .clk    (clk),
    .rst    (rst),
    .step   (advance && odd),
    .clear  (advance && last),
    .elem   (wide_elem),
    .where  (wide_where),
    .cfg    (cfg),
    .status (wide_status)
  );

  // result selection, narrow first
  always_comb begin
    if (narrow_status.hit) begin
      result_next.string_address = cfg.section_base +
          {{(psrs_pkg::ADDR_BITS-psrs_pkg::OFFSET_BITS){1'b0}}, narrow_status.start};
      result_next.byte_length = {1'b0, narrow_status.count};
      result_next.is_wide = 1'b0;
    end else begin
      result_next.string_address = cfg.section_base +
          {{(psrs_pkg::ADDR_BITS-psrs_pkg::OFFSET_BITS){1'b0}},
           wide_status.start[psrs_pkg::UNIT_BITS-1:0], 1'b0};
      result_next.byte_length = {wide_status.count, 1'b0};
      result_next.is_wide = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= narrow_status.hit || wide_status.hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    !(narrow_status.hit && wide_status.hit))
    else $error("narrow and wide runs ended on the same byte");

  a_section_restart: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> pos == '0)
    else $error("offset not cleared after section end");

  a_length_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.byte_length != '0 &&
                  (!out_item.is_wide || !out_item.byte_length[0]))
    else $error("reported run length malformed");

endmodule

// ----- dv/printable_string_run_scanner_tb.sv -----
`timescale 1ns / 1ps

module printable_string_run_scanner_tb;

  localparam int NARROW = 0;
  localparam int WIDE = 1;

  // predicts the strings the scanner reports and checks them in order
  class run_scoreboard;
    logic [psrs_pkg::ADDR_BITS-1:0] base;
    logic [psrs_pkg::COUNT_BITS-1:0] min_len;
    logic [psrs_pkg::COUNT_BITS-1:0] max_len;
    logic [psrs_pkg::OFFSET_BITS-1:0] pos;
    bit in_run[2];
    logic [psrs_pkg::OFFSET_BITS-1:0] run_start[2];
    logic [psrs_pkg::COUNT_BITS-1:0] run_count[2];
    logic [7:0] low_byte;
    psrs_pkg::out_item_t expected_strings[$];
    int errors;
    int narrow_found;
    int wide_found;

    function new();
      base = psrs_pkg::RESET_SECTION_BASE;
      min_len = psrs_pkg::RESET_MIN_RUN;
      max_len = psrs_pkg::RESET_MAX_RUN;
      errors = 0;
      narrow_found = 0;
      wide_found = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      pos = '0;
      low_byte = '0;
      for (int s = 0; s < 2; s++) begin
        in_run[s] = 1'b0;
        run_start[s] = '0;
        run_count[s] = '0;
      end
    endfunction

    function void set_reg(logic [psrs_pkg::CFG_INDEX_BITS-1:0] idx,
                          logic [psrs_pkg::CFG_DATA_BITS-1:0] val);
      case (idx)
        psrs_pkg::REG_SECTION_BASE: base = val;
        psrs_pkg::REG_MIN_RUN_LENGTH: min_len = val[psrs_pkg::COUNT_BITS-1:0];
        psrs_pkg::REG_MAX_RUN_LENGTH: max_len = val[psrs_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit is_text(logic [15:0] v);
      return (v >= 16'h0020 && v <= 16'h007E) || v == 16'h0009 || v == 16'h000A ||
             v == 16'h000D;
    endfunction

    // one element into scanner s, true when a terminated run qualifies
    function bit scan(int s, logic [15:0] v, logic [psrs_pkg::OFFSET_BITS-1:0] where);
      bit hit;
      hit = 1'b0;
      if (in_run[s]) begin
        if (run_count[s] < max_len && is_text(v)) begin
          run_count[s] = run_count[s] + 1'b1;
        end else begin
          hit = (v == 16'h0000) && (run_count[s] >= min_len);
          in_run[s] = 1'b0;
        end
      end else if (is_text(v) && max_len != 0) begin
        in_run[s] = 1'b1;
        run_start[s] = where;
        run_count[s] = 16'd1;
      end
      return hit;
    endfunction

    // accepted section byte: advance both scanners
    function void note_byte(psrs_pkg::in_item_t it);
      bit narrow_hit;
      bit wide_hit;
      psrs_pkg::out_item_t e;
      narrow_hit = scan(NARROW, {8'h00, it.data_byte}, pos);
      wide_hit = 1'b0;
      if (!pos[0]) begin
        low_byte = it.data_byte;
      end else begin
        wide_hit = scan(WIDE, {it.data_byte, low_byte},
                        {1'b0, pos[psrs_pkg::OFFSET_BITS-1:1]});
      end
      if (narrow_hit) begin
        e.string_address = base + psrs_pkg::ADDR_BITS'(run_start[NARROW]);
        e.byte_length = psrs_pkg::LEN_BITS'(run_count[NARROW]);
        e.is_wide = 1'b0;
        expected_strings = {expected_strings, e};
      end else if (wide_hit) begin
        e.string_address = base +
            psrs_pkg::ADDR_BITS'({run_start[WIDE][psrs_pkg::UNIT_BITS-1:0], 1'b0});
        e.byte_length = {run_count[WIDE], 1'b0};
        e.is_wide = 1'b1;
        expected_strings = {expected_strings, e};
      end
      if (it.last_in_section) begin
        clear_scan();
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    function void report(string what, psrs_pkg::out_item_t want, psrs_pkg::out_item_t got);
      errors++;
      if (errors <= 10) begin
        $display("%0t %s: expected addr %h len %0d wide %0d, got addr %h len %0d wide %0d",
                 $realtime, what, want.string_address, want.byte_length, want.is_wide,
                 got.string_address, got.byte_length, got.is_wide);
      end
    endfunction

    // accepted result: compare with the oldest predicted string
    function void check_result(psrs_pkg::out_item_t got);
      psrs_pkg::out_item_t want;
      if (expected_strings.size() == 0) begin
        report("string with none pending", '0, got);
        return;
      end
      want = expected_strings.pop_front();
      if (got.string_address !== want.string_address || got.byte_length !== want.byte_length ||
          got.is_wide !== want.is_wide) begin
        report("string mismatch", want, got);
      end else if (got.is_wide) begin
        wide_found++;
      end else begin
        narrow_found++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  psrs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psrs_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psrs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [psrs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  run_scoreboard sb;
  bit quiet;
  int gen_pos;
  int items_sent;
  int settings_run;
  logic [psrs_pkg::COUNT_BITS-1:0] cur_min;
  logic [psrs_pkg::COUNT_BITS-1:0] cur_max;

  printable_string_run_scanner dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_byte(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls
  initial begin : out_side
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall = pick_gap();
      end
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0D;
      3: return 8'h20;
      4: return 8'h7E;
      default: return 8'($urandom_range(8'h21, 8'h7D));
    endcase
  endfunction

  // nonzero byte that breaks a run
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom); while (b == 8'h00 || sb.is_text({8'h00, b}));
    return b;
  endfunction

  // run lengths around the current min and max
  function automatic int pick_len();
    int n;
    case ($urandom_range(0, 9))
      0: n = int'(cur_min) - 1;
      1: n = int'(cur_min);
      2: n = int'(cur_min) + 1;
      3: n = int'(cur_max);
      4: n = int'(cur_max) + 1;
      default: n = $urandom_range(1, 12);
    endcase
    if (n < 1 || n > 80) n = $urandom_range(1, 12);
    return n;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    psrs_pkg::in_item_t it;
    gap = pick_gap();
    it.data_byte = b;
    it.last_in_section = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gen_pos = last ? 0 : gen_pos + 1;
  endtask

  // ascii run, usually zero terminated
  task automatic send_text_run();
    int n;
    int r;
    n = pick_len();
    repeat (n) send_byte(pick_char(), 1'b0);
    r = $urandom_range(0, 99);
    if (r < 75) send_byte(8'h00, $urandom_range(0, 9) == 0);
    else if (r < 90) send_byte(pick_junk(), 1'b0);
    else send_byte(pick_char(), 1'b0);
  endtask

  // utf-16le run on an even offset, usually ended by a zero unit
  task automatic send_wide_run();
    int n;
    int r;
    if (gen_pos % 2 != 0) send_byte(8'($urandom), 1'b0);
    n = pick_len();
    repeat (n) begin
      send_byte(pick_char(), 1'b0);
      send_byte(8'h00, 1'b0);
    end
    r = $urandom_range(0, 99);
    send_byte(r < 85 ? 8'h00 : pick_char(), 1'b0);
    if (r < 75) send_byte(8'h00, $urandom_range(0, 9) == 0);
    else send_byte(8'($urandom_range(1, 255)), 1'b0);
  endtask

  task automatic random_bytes(int budget);
    int stop;
    int r;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_text_run();
      end else if (r < 65) begin
        send_wide_run();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'b1);
      end
    end
  endtask

  // drain all pending strings, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_strings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] base, logic [15:0] min_len, logic [15:0] max_len);
    psrs_pkg::cfg_reg_t idx[3];
    logic [63:0] val[3];
    idx[0] = psrs_pkg::REG_SECTION_BASE;
    idx[1] = psrs_pkg::REG_MIN_RUN_LENGTH;
    idx[2] = psrs_pkg::REG_MAX_RUN_LENGTH;
    val[0] = base;
    val[1] = {48'h0, min_len};
    val[2] = {48'h0, max_len};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_min = min_len;
    cur_max = max_len;
    settings_run++;
  endtask

  task automatic directed();
    logic [7:0] seq[$];
    // wide "ABCD", ascii "Test", the control and bound characters, then an open run cut
    // off by the section end
    seq = {8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00, 8'h00, 8'h00,
           8'h54, 8'h65, 8'h73, 8'h74, 8'h00,
           8'h09, 8'h0A, 8'h0D, 8'h7E, 8'h20, 8'h00,
           8'hFF, 8'h78, 8'h79, 8'h7A, 8'h77};
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  initial begin : main
    sb = new();
    quiet = 1'b0;
    gen_pos = 0;
    items_sent = 0;
    settings_run = 1;
    cur_min = psrs_pkg::RESET_MIN_RUN;
    cur_max = psrs_pkg::RESET_MAX_RUN;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    random_bytes(200);

    // address wrap past 2^64, tiny cut length
    wait_idle();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'd8);
    random_bytes(200);

    // one-character runs with no minimum, back to back
    wait_idle();
    quiet = 1'b1;
    configure(64'h0123_4567_89AB_CDEF, 16'd0, 16'd1);
    random_bytes(150);
    quiet = 1'b0;

    wait_idle();
    configure('0, 16'd3, 16'hFFFF);
    random_bytes(150);

    // minimum never reached
    wait_idle();
    configure(64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 16'hFFFF);
    random_bytes(80);

    // zero maximum: no run can start
    wait_idle();
    configure({$urandom, $urandom}, 16'd1, 16'd0);
    random_bytes(60);

    wait_idle();
    configure({$urandom, $urandom}, 16'd2, 16'd5);
    random_bytes(120);
    quiet = 1'b1;
    random_bytes(100);
    quiet = 1'b0;

    wait_idle();
    $display("sent %0d section bytes under %0d register settings", items_sent, settings_run);
    $display("matched %0d ascii and %0d utf-16le strings, %0d mismatches",
             sb.narrow_found, sb.wide_found, sb.errors);
    if (sb.errors == 0 && sb.expected_strings.size() == 0) begin
      $display("printable_string_run_scanner_tb passed");
    end else begin
      $display("printable_string_run_scanner_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("timeout with %0d strings pending", sb.expected_strings.size());
    $display("printable_string_run_scanner_tb failed");
    $finish;
  end

endmodule
